@@ rtl/svg_pkg.sv @@
// Package of the UV sphere mesh generator: shared widths, codes, the command
// that travels from the front to the back, and the CORDIC arctangent table.
// No dependencies.
package svg_pkg;

  localparam int CntW = 7;
  localparam int RadW = 16;
  localparam int IdxW = 13;
  localparam int CoordW = 17;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int InTdataW = 8;
  localparam int OutTdataW = 96;
  localparam int CordicSteps = 24;
  localparam int CordicStepW = 5;
  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicGainInv = 34'sd652032874;
  localparam logic signed [16:0] CoordLimit = 17'sd65535;

  localparam logic [CfgIdxW-1:0] RegRadius = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLon = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLat = 2'd2;

  typedef enum logic [1:0] {
    CMD_POLE,
    CMD_RING,
    CMD_TRI
  } cmd_e;

  typedef struct packed {
    cmd_e            kind;
    logic            south;
    logic [CntW-1:0] ring;
    logic [CntW-1:0] col;
    logic [CntW-1:0] lat;
    logic [CntW-1:0] lon;
    logic [RadW-1:0] radius;
    logic [IdxW-1:0] corner_a;
    logic [IdxW-1:0] corner_b;
    logic [IdxW-1:0] corner_c;
    logic            last;
  } cmd_t;

  function automatic logic [31:0] atan_turn(input logic [CordicStepW-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/svg_front.sv @@
// Front of the sphere generator: configuration registers, restart handling and
// the mesh sequencer that turns each accepted transfer into at most one command.
// Depends on svg_pkg.
module svg_front import svg_pkg::*; #(
  parameter int MAX_LONGITUDE = 64,
  parameter int MAX_LATITUDE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  input  logic                q_full_i,
  output logic                push_o,
  output cmd_t                cmd_o
);

  typedef enum logic [2:0] {
    PH_NPOLE, PH_RING, PH_SPOLE, PH_NFAN, PH_QUAD, PH_SFAN, PH_DONE
  } phase_e;

  phase_e          phase_q, phase_d, ph;
  logic [RadW-1:0] cfg_rad_q, use_rad_q, rad;
  logic [CntW-1:0] cfg_lon_q, cfg_lat_q, use_lon_q, use_lat_q, lon, lat;
  logic [CntW-1:0] ring_q, ring_d, col_q, col_d, ring, col, col_n, ring_n;
  logic            half_q, half_d, half;
  logic [CntW-1:0] lon_clamp, lat_clamp;
  logic [IdxW-1:0] south, base, below, below_r, right;
  logic            accept;

  always_comb begin
    if (cfg_lon_q < 7'd2) begin
      lon_clamp = 7'd2;
    end else if (32'(cfg_lon_q) > MAX_LONGITUDE) begin
      lon_clamp = 7'(MAX_LONGITUDE);
    end else begin
      lon_clamp = cfg_lon_q;
    end
    if (cfg_lat_q < 7'd1) begin
      lat_clamp = 7'd1;
    end else if (32'(cfg_lat_q) > MAX_LATITUDE) begin
      lat_clamp = 7'(MAX_LATITUDE);
    end else begin
      lat_clamp = cfg_lat_q;
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && !q_full_i;

  always_comb begin
    if (restart_i) begin
      ph = PH_NPOLE;
      ring = '0;
      col = '0;
      half = 1'b0;
      rad = cfg_rad_q;
      lon = lon_clamp;
      lat = lat_clamp;
    end else begin
      ph = phase_q;
      ring = ring_q;
      col = col_q;
      half = half_q;
      rad = use_rad_q;
      lon = use_lon_q;
      lat = use_lat_q;
    end
    col_n = col + 7'd1;
    ring_n = ring + 7'd1;
    south = 13'({6'b0, lat} * {6'b0, lon}) + 13'd1;
    base = 13'({6'b0, ring} * {6'b0, lon}) + 13'(col) + 13'd1;
    below = base + 13'(lon);
    below_r = below + 13'd1;
    right = base + 13'd1;
    if (col == lon - 7'd1) begin
      below_r = below_r - 13'(lon);
      right = right - 13'(lon);
    end

    phase_d = ph;
    ring_d = ring;
    col_d = col;
    half_d = half;
    cmd_o.kind = CMD_TRI;
    cmd_o.south = 1'b0;
    cmd_o.ring = ring;
    cmd_o.col = col;
    cmd_o.lat = lat;
    cmd_o.lon = lon;
    cmd_o.radius = rad;
    cmd_o.corner_a = '0;
    cmd_o.corner_b = '0;
    cmd_o.corner_c = '0;
    cmd_o.last = 1'b0;
    unique case (ph)
      PH_NPOLE: begin
        cmd_o.kind = CMD_POLE;
        phase_d = PH_RING;
        ring_d = '0;
        col_d = '0;
      end
      PH_RING: begin
        cmd_o.kind = CMD_RING;
        col_d = col_n;
        if (col_n >= lon) begin
          col_d = '0;
          ring_d = ring_n;
          if (ring_n >= lat) begin
            phase_d = PH_SPOLE;
          end
        end
      end
      PH_SPOLE: begin
        cmd_o.kind = CMD_POLE;
        cmd_o.south = 1'b1;
        phase_d = PH_NFAN;
        ring_d = '0;
        col_d = '0;
      end
      PH_NFAN: begin
        cmd_o.corner_b = 13'(col) + 13'd1;
        cmd_o.corner_c = (col == lon - 7'd1) ? 13'd1 : 13'(col) + 13'd2;
        col_d = col_n;
        if (col_n >= lon) begin
          col_d = '0;
          ring_d = '0;
          half_d = 1'b0;
          phase_d = (lat > 7'd1) ? PH_QUAD : PH_SFAN;
        end
      end
      PH_QUAD: begin
        cmd_o.corner_a = base;
        if (!half) begin
          cmd_o.corner_b = below;
          cmd_o.corner_c = below_r;
          half_d = 1'b1;
        end else begin
          cmd_o.corner_b = below_r;
          cmd_o.corner_c = right;
          half_d = 1'b0;
          col_d = col_n;
          if (col_n >= lon) begin
            col_d = '0;
            ring_d = ring_n;
            if (ring_n >= lat - 7'd1) begin
              phase_d = PH_SFAN;
            end
          end
        end
      end
      PH_SFAN: begin
        cmd_o.corner_a = south;
        cmd_o.corner_b = (col == 7'd0) ? south - 13'(lon) : south - 13'(col);
        cmd_o.corner_c = south - 13'(col_n);
        col_d = col_n;
        if (col_n >= lon) begin
          cmd_o.last = 1'b1;
          col_d = '0;
          phase_d = PH_DONE;
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  assign push_o = accept && (ph != PH_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      ring_q <= '0;
      col_q <= '0;
      half_q <= 1'b0;
      cfg_rad_q <= 16'd256;
      cfg_lon_q <= 7'd8;
      cfg_lat_q <= 7'd4;
      use_rad_q <= '0;
      use_lon_q <= '0;
      use_lat_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegRadius: cfg_rad_q <= cfg_data_i;
          RegLon: cfg_lon_q <= cfg_data_i[CntW-1:0];
          RegLat: cfg_lat_q <= cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_q <= phase_d;
        ring_q <= ring_d;
        col_q <= col_d;
        half_q <= half_d;
        use_rad_q <= rad;
        use_lon_q <= lon;
        use_lat_q <= lat;
      end
    end
  end

endmodule

@@ rtl/svg_queue.sv @@
// Two-entry command queue between the front and the back of the generator.
// Depends on svg_pkg.
module svg_queue import svg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ rtl/svg_div.sv @@
// Restoring divider, one quotient bit per cycle, for the ring angles.
// Depends on svg_pkg only through the house import.
module svg_div import svg_pkg::*; #(
  parameter int NW = 24,
  parameter int DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW);

  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial, diff;
  logic          take;

  assign trial = {rem_q, quo_q[NW-1]};
  assign take = trial >= {1'b0, den_q};
  assign diff = trial - {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/svg_cordic.sv @@
// Iterative CORDIC sine and cosine of a turn fraction, one rotation per cycle,
// results in Q2.30. Depends on svg_pkg for the arctangent table and gain.
module svg_cordic import svg_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ANGLE_BITS-1:0] ang_i,
  output logic                  done_o,
  output logic signed [31:0]    cos_o,
  output logic signed [31:0]    sin_o
);

  logic [31:0]                a32, a_off, resid;
  logic [1:0]                 quad, quad_q;
  logic signed [CordicW-1:0]  x_q, y_q, z_q, xs, ys, at, c, s;
  logic [CordicStepW-1:0]     i_q;
  logic                       busy_q, done_q;

  assign a32 = 32'(ang_i) << (32 - ANGLE_BITS);
  assign a_off = a32 + 32'h2000_0000;
  assign quad = a_off[31:30];
  assign resid = a32 - {quad, 30'b0};
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = CordicW'(atan_turn(i_q));
  assign done_o = done_q;

  always_comb begin
    unique case (quad_q)
      2'd0: begin c = x_q; s = y_q; end
      2'd1: begin c = -y_q; s = x_q; end
      2'd2: begin c = -x_q; s = -y_q; end
      default: begin c = y_q; s = -x_q; end
    endcase
  end

  assign cos_o = c[31:0];
  assign sin_o = s[31:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CordicGainInv;
      y_q <= '0;
      z_q <= {{(CordicW-32){resid[31]}}, resid};
      quad_q <= quad;
    end else if (busy_q) begin
      if (!z_q[CordicW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == 5'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/svg_back.sv @@
// Back of the sphere generator: executes queued commands, computing ring
// vertices with the dividers, two CORDIC units and one shared multiplier,
// and holds the output register. Depends on svg_pkg, svg_div and svg_cordic.
module svg_back import svg_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  cmd_t                 q_cmd_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_kind_o,
  output logic [CoordW-1:0]    out_x_o,
  output logic [CoordW-1:0]    out_y_o,
  output logic [CoordW-1:0]    out_z_o,
  output logic [IdxW-1:0]      out_a_o,
  output logic [IdxW-1:0]      out_b_o,
  output logic [IdxW-1:0]      out_c_o,
  output logic                 out_last_o
);

  localparam int NW = ANGLE_BITS + 8;
  localparam int DW = 9;

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_ROT, B_MUL, B_OUT} bstate_e;

  bstate_e              state_q;
  logic [2:0]           step_q;
  logic [RadW-1:0]      rad_q;
  logic signed [31:0]   xs_q, ys_q, ma, mb;
  logic signed [63:0]   prod_q;
  logic signed [33:0]   rnd;
  logic [CoordW-1:0]    sat, vx_q, vy_q, vz_q;
  logic                 out_free, start_div, start_rot, out_load;
  logic [NW-1:0]        num_t, num_p, quo_t, quo_p;
  logic [DW-1:0]        den_t, den_p;
  logic                 div_done, div_done_p, rot_done, rot_done_s;
  logic signed [31:0]   ct, st, cp, sp;
  logic signed [31:0]   rad_s;
  logic signed [CoordW-1:0] pole_z;

  logic                 ov_q, okind_q, olast_q;
  logic [CoordW-1:0]    ox_q, oy_q, oz_q;
  logic [IdxW-1:0]      oa_q, ob_q, oc_q;

  assign out_free = !ov_q || out_ready_i;

  assign num_t = ((NW'(q_cmd_i.ring) + NW'(1)) << ANGLE_BITS) + NW'(q_cmd_i.lat) + NW'(1);
  assign den_t = {({1'b0, q_cmd_i.lat} + 8'd1), 1'b0};
  assign num_p = (NW'(q_cmd_i.col) << ANGLE_BITS) + NW'(q_cmd_i.lon[CntW-1:1]);
  assign den_p = DW'(q_cmd_i.lon);

  assign start_div = (state_q == B_IDLE) && q_valid_i && (q_cmd_i.kind == CMD_RING);
  assign start_rot = (state_q == B_DIV) && div_done;
  assign q_pop_o = (state_q == B_IDLE) && q_valid_i && ((q_cmd_i.kind == CMD_RING) || out_free);
  assign out_load = ((state_q == B_IDLE) && q_valid_i && (q_cmd_i.kind != CMD_RING) && out_free)
                    || ((state_q == B_OUT) && out_free);

  svg_div #(.NW(NW), .DW(DW)) u_div_t (
    .clk_i, .rst_ni, .start_i(start_div), .num_i(num_t), .den_i(den_t),
    .done_o(div_done), .quo_o(quo_t)
  );

  svg_div #(.NW(NW), .DW(DW)) u_div_p (
    .clk_i, .rst_ni, .start_i(start_div), .num_i(num_p), .den_i(den_p),
    .done_o(div_done_p), .quo_o(quo_p)
  );

  svg_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_rot_t (
    .clk_i, .rst_ni, .start_i(start_rot), .ang_i(quo_t[ANGLE_BITS-1:0]),
    .done_o(rot_done), .cos_o(ct), .sin_o(st)
  );

  svg_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_rot_p (
    .clk_i, .rst_ni, .start_i(start_rot), .ang_i(quo_p[ANGLE_BITS-1:0]),
    .done_o(rot_done_s), .cos_o(cp), .sin_o(sp)
  );

  assign rad_s = signed'({16'b0, rad_q});
  assign pole_z = q_cmd_i.south ? -signed'({1'b0, q_cmd_i.radius})
                                : signed'({1'b0, q_cmd_i.radius});

  always_comb begin
    unique case (step_q)
      3'd0: begin ma = st; mb = cp; end
      3'd1: begin ma = st; mb = sp; end
      3'd2: begin ma = ct; mb = rad_s; end
      3'd3: begin ma = xs_q; mb = rad_s; end
      default: begin ma = ys_q; mb = rad_s; end
    endcase
  end

  assign rnd = 34'((prod_q + 64'sd536870912) >>> 30);

  always_comb begin
    if (rnd > 34'sd65535) begin
      sat = CoordLimit;
    end else if (rnd < -34'sd65535) begin
      sat = -CoordLimit;
    end else begin
      sat = rnd[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    if (start_div) begin
      rad_q <= q_cmd_i.radius;
    end
    if (state_q == B_MUL) begin
      unique case (step_q)
        3'd1: xs_q <= rnd[31:0];
        3'd2: ys_q <= rnd[31:0];
        3'd3: vz_q <= sat;
        3'd4: vx_q <= sat;
        3'd5: vy_q <= sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      step_q <= '0;
      ov_q <= 1'b0;
      okind_q <= 1'b0;
      olast_q <= 1'b0;
      oa_q <= '0;
      ob_q <= '0;
      oc_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      oz_q <= '0;
    end else begin
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (q_valid_i && q_cmd_i.kind == CMD_RING) begin
            state_q <= B_DIV;
          end else if (q_valid_i && out_free) begin
            okind_q <= q_cmd_i.kind == CMD_TRI;
            olast_q <= q_cmd_i.last;
            oa_q <= q_cmd_i.corner_a;
            ob_q <= q_cmd_i.corner_b;
            oc_q <= q_cmd_i.corner_c;
            ox_q <= '0;
            oy_q <= '0;
            oz_q <= (q_cmd_i.kind == CMD_TRI) ? '0 : pole_z;
          end
        end
        B_DIV: begin
          if (div_done) begin
            state_q <= B_ROT;
          end
        end
        B_ROT: begin
          if (rot_done) begin
            state_q <= B_MUL;
            step_q <= '0;
          end
        end
        B_MUL: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd5) begin
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            okind_q <= 1'b0;
            olast_q <= 1'b0;
            oa_q <= '0;
            ob_q <= '0;
            oc_q <= '0;
            ox_q <= vx_q;
            oy_q <= vy_q;
            oz_q <= vz_q;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o = okind_q;
  assign out_last_o = olast_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_z_o = oz_q;
  assign out_a_o = oa_q;
  assign out_b_o = ob_q;
  assign out_c_o = oc_q;

  logic unused_done;
  assign unused_done = div_done_p ^ rot_done_s;

endmodule

@@ rtl/uv_sphere_mesh_generator.sv @@
// UV sphere mesh generator, top level. A triangle or pole result passes through
// the command queue and the output register; a ring vertex also passes through
// the serial angle dividers, the 24-step CORDIC loop and the shared multiplier.
// Up to two commands wait in the queue. Reset is asynchronous and active low;
// after reset nothing is emitted until a restart. Depends on svg_pkg,
// svg_front, svg_queue and svg_back.
module uv_sphere_mesh_generator import svg_pkg::*; #(
  parameter int MAX_LONGITUDE = 64,
  parameter int MAX_LATITUDE = 64,
  parameter int ANGLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // restart in bit 0, zeros above
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // vert_x, vert_y, vert_z, corner_a, corner_b, corner_c, then zero fill
  output logic [OutTdataW-1:0] m_axis_tdata,
  // kind
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);

  cmd_t              f_cmd, q_cmd;
  logic              push, full, q_valid, pop;
  logic [CoordW-1:0] vx, vy, vz;
  logic [IdxW-1:0]   ca, cb, cc;
  logic [InTdataW-2:0] unused_in;

  assign unused_in = s_axis_tdata[InTdataW-1:1];

  svg_front #(.MAX_LONGITUDE(MAX_LONGITUDE), .MAX_LATITUDE(MAX_LATITUDE)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .restart_i(s_axis_tdata[0]), .q_full_i(full), .push_o(push), .cmd_o(f_cmd)
  );

  svg_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(f_cmd), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .cmd_o(q_cmd)
  );

  svg_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_kind_o(m_axis_tuser), .out_x_o(vx), .out_y_o(vy), .out_z_o(vz),
    .out_a_o(ca), .out_b_o(cb), .out_c_o(cc), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, cc, cb, ca, vz, vy, vx};

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench of uv_sphere_mesh_generator: stream transfers with
// random idling, a mesh predictor and a queue of expected mesh elements.
// Depends on svg_pkg and the RTL of the mesh generator.
module testbench;
  import svg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               kind;
    logic signed [16:0] vx;
    logic signed [16:0] vy;
    logic signed [16:0] vz;
    logic [12:0]        ca;
    logic [12:0]        cb;
    logic [12:0]        cc;
    logic               last;
  } elem_t;

  typedef enum int {ST_NPOLE, ST_RING, ST_SPOLE, ST_NFAN, ST_QUAD, ST_SFAN, ST_DONE}
    mesh_state_e;

  localparam int MaxIdle = 5000;
  localparam int Drain = 150;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InTdataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  uv_sphere_mesh_generator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mesh predictor state.
  logic [15:0] reg_radius = 16'd256;
  logic [6:0] reg_lon = 7'd8, reg_lat = 7'd4;
  mesh_state_e mstate = ST_DONE;
  int unsigned ring_n, col_n, half_n, m_radius, m_lon, m_lat;

  longint atan_tab [24] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

  elem_t expected_elems[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  bit timed_out = 1'b0;
  bit send_typed = 1'b0;
  elem_t typed_elem;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit pressure_req = 1'b0;

  function automatic longint rq30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [16:0] sat_coord(longint v);
    if (v > 65535) v = 65535;
    if (v < -65535) v = -65535;
    return v[16:0];
  endfunction

  task automatic turn_sincos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a32, q, rem;
    longint x, y, z, nx;
    a32 = {ang, 16'h0};
    q = ((a32 + 32'h20000000) >> 30) & 32'd3;
    rem = a32 - (q << 30);
    z = longint'(rem);
    if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic elem_t tri_elem(int unsigned a, int unsigned b, int unsigned c);
    elem_t e = '0;
    e.kind = 1'b1;
    e.ca = a[12:0];
    e.cb = b[12:0];
    e.cc = c[12:0];
    return e;
  endfunction

  task automatic mesh_step(input bit restart, output bit produced, output elem_t e);
    int unsigned south, base, below, below_r, right;
    longint ct, st, cp, sp, r;
    logic [15:0] at, ap;
    e = '0;
    produced = 1'b0;
    if (restart) begin
      m_radius = reg_radius;
      m_lon = (reg_lon < 2) ? 2 : (reg_lon > 64) ? 64 : reg_lon;
      m_lat = (reg_lat < 1) ? 1 : (reg_lat > 64) ? 64 : reg_lat;
      mstate = ST_NPOLE;
      ring_n = 0;
      col_n = 0;
      half_n = 0;
    end
    if (mstate == ST_DONE) return;
    produced = 1'b1;
    south = m_lat * m_lon + 1;
    r = m_radius;
    case (mstate)
      ST_NPOLE: begin
        e.vz = sat_coord(r);
        mstate = ST_RING;
        ring_n = 0;
        col_n = 0;
      end
      ST_RING: begin
        at = 16'(((longint'(ring_n + 1) << 16) + (m_lat + 1)) / (2 * (m_lat + 1)));
        ap = 16'(((longint'(col_n) << 16) + m_lon / 2) / m_lon);
        turn_sincos(at, ct, st);
        turn_sincos(ap, cp, sp);
        e.vx = sat_coord(rq30(rq30(st * cp) * r));
        e.vy = sat_coord(rq30(rq30(st * sp) * r));
        e.vz = sat_coord(rq30(ct * r));
        col_n++;
        if (col_n >= m_lon) begin
          col_n = 0;
          ring_n++;
          if (ring_n >= m_lat) mstate = ST_SPOLE;
        end
      end
      ST_SPOLE: begin
        e.vz = sat_coord(-r);
        mstate = ST_NFAN;
        ring_n = 0;
        col_n = 0;
      end
      ST_NFAN: begin
        e = tri_elem(0, col_n + 1, (col_n == m_lon - 1) ? 1 : col_n + 2);
        col_n++;
        if (col_n >= m_lon) begin
          col_n = 0;
          ring_n = 0;
          half_n = 0;
          mstate = (m_lat > 1) ? ST_QUAD : ST_SFAN;
        end
      end
      ST_QUAD: begin
        base = ring_n * m_lon + col_n + 1;
        below = base + m_lon;
        below_r = below + 1;
        right = base + 1;
        if (col_n == m_lon - 1) begin
          below_r -= m_lon;
          right -= m_lon;
        end
        if (half_n == 0) begin
          e = tri_elem(base, below, below_r);
          half_n = 1;
        end else begin
          e = tri_elem(base, below_r, right);
          half_n = 0;
          col_n++;
          if (col_n >= m_lon) begin
            col_n = 0;
            ring_n++;
            if (ring_n >= m_lat - 1) mstate = ST_SFAN;
          end
        end
      end
      default: begin
        e = tri_elem(south, (col_n == 0) ? south - m_lon : south - col_n, south - (col_n + 1));
        col_n++;
        if (col_n >= m_lon) begin
          e.last = 1'b1;
          col_n = 0;
          mstate = ST_DONE;
        end
      end
    endcase
  endtask

  // Predicts on input transfers and checks output transfers.
  always @(posedge clk_i) begin
    bit produced;
    elem_t e, got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRadius: reg_radius = cfg_data_i;
          RegLon: reg_lon = cfg_data_i[6:0];
          RegLat: reg_lat = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        mesh_step(s_axis_tdata[0], produced, e);
        if (produced) begin
          expected_elems.insert(expected_elems.size(), send_typed ? typed_elem : e);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.vx = m_axis_tdata[16:0];
        got.vy = m_axis_tdata[33:17];
        got.vz = m_axis_tdata[50:34];
        got.ca = m_axis_tdata[63:51];
        got.cb = m_axis_tdata[76:64];
        got.cc = m_axis_tdata[89:77];
        got.last = m_axis_tlast;
        if (expected_elems.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output transfer %p", got);
        end else begin
          e = expected_elems.pop_front();
          if (got.kind !== e.kind || got.vx !== e.vx || got.vy !== e.vy ||
              got.vz !== e.vz || got.ca !== e.ca || got.cb !== e.cb ||
              got.cc !== e.cc || got.last !== e.last || m_axis_tdata[95:90] !== '0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= MaxIdle && !timed_out) begin
          timed_out = 1'b1;
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, and one long hold-off to fill the block up.
  always @(negedge clk_i) begin
    static int hold_cnt = 0;
    static bit pressure_done = 1'b0;
    if (pressure_req && !pressure_done) begin
      pressure_done = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input bit restart);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  task automatic settle;
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    wait (expected_elems.size() == 0);
    repeat (Drain) @(negedge clk_i);
  endtask

  typedef struct {
    bit    restart;
    bit    typed;
    elem_t value;
  } row_t;

  row_t directed [12];
  int cfg_r [6] = '{65535, 0, 1000, 300, 65535, 200};
  int cfg_lon [6] = '{127, 0, 2, 64, 64, 3};
  int cfg_lat [6] = '{127, 0, 64, 1, 64, 1};

  initial begin
    int phase_n, mesh_len, lon_c, lat_c, n_items;
    elem_t np;
    np = '0;
    np.vz = 17'sd256;
    foreach (directed[i]) directed[i] = '{restart: 1'b0, typed: 1'b0, value: '0};
    directed[1] = '{restart: 1'b1, typed: 1'b1, value: np};
    directed[7].restart = 1'b1;
    directed[8] = '{restart: 1'b1, typed: 1'b1, value: np};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      send_typed <= directed[i].typed;
      typed_elem <= directed[i].value;
      send_item(directed[i].restart);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    send_typed <= 1'b0;

    phase_n = 0;
    while (items_sent < 1550) begin
      settle();
      case (phase_n % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 58; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 58; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (phase_n < 6) begin
        write_reg(RegRadius, 16'(cfg_r[phase_n]));
        write_reg(RegLon, 16'(cfg_lon[phase_n]));
        write_reg(RegLat, 16'(cfg_lat[phase_n]));
      end else begin
        write_reg(RegRadius, 16'(($urandom_range(3) == 0) ? $urandom_range(65535)
                                                           : $urandom_range(2000)));
        write_reg(RegLon, 16'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                       : $urandom_range(2, 8)));
        write_reg(RegLat, 16'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                       : $urandom_range(1, 4)));
        if ($urandom_range(4) == 0) write_reg(RegUnused, 16'($urandom_range(65535)));
      end
      if (phase_n == 4) pressure_req = 1'b1;
      lon_c = (reg_lon < 2) ? 2 : (reg_lon > 64) ? 64 : reg_lon;
      lat_c = (reg_lat < 1) ? 1 : (reg_lat > 64) ? 64 : reg_lat;
      mesh_len = 3 * lon_c * lat_c + 2;
      n_items = (mesh_len > 250) ? 250 : mesh_len + $urandom_range(3);
      send_item(1'b1);
      for (int i = 1; i < n_items && items_sent < 1550; i++) begin
        // A restart in the middle of a mesh now and then.
        send_item($urandom_range(39) == 0);
      end
      // A register write while a mesh is under way must not take effect.
      if (phase_n % 3 == 1) begin
        settle();
        write_reg(RegLon, 16'($urandom_range(2, 6)));
        send_item(1'b1);
        settle();
        write_reg(RegLon, 16'($urandom_range(2, 6)));
        write_reg(RegRadius, 16'($urandom_range(65535)));
        for (int i = 0; i < 20; i++) send_item(1'b0);
      end
      phase_n++;
    end

    settle();
    if (mismatches == 0 && expected_elems.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/svg_pkg.sv
rtl/svg_front.sv
rtl/svg_queue.sv
rtl/svg_div.sv
rtl/svg_cordic.sv
rtl/svg_back.sv
rtl/uv_sphere_mesh_generator.sv
bench/testbench.sv
